// File: sv/rtc_pkg.sv
package rtc_pkg;

   // Vertex capacity of one clipping pass and fraction bits of every coordinate.
   localparam int MAX_VERTICES  = 8;
   localparam int FRACTION_BITS = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_CORNER,
      ST_CULL,
      ST_PASS,
      ST_VISIT,
      ST_MULX,
      ST_DIV,
      ST_PUSH,
      ST_EMIT
   } state_type;

   localparam logic [2:0] REG_COSINE        = 3'd0;
   localparam logic [2:0] REG_SINE          = 3'd1;
   localparam logic [2:0] REG_SCALED_COSINE = 3'd2;
   localparam logic [2:0] REG_SCALED_SINE   = 3'd3;
   localparam logic [2:0] REG_VIEW_LEFT     = 3'd4;
   localparam logic [2:0] REG_VIEW_TOP      = 3'd5;
   localparam logic [2:0] REG_VIEW_WIDTH    = 3'd6;
   localparam logic [2:0] REG_VIEW_HEIGHT   = 3'd7;

   localparam logic [1:0] EDGE_LEFT   = 2'd0;
   localparam logic [1:0] EDGE_TOP    = 2'd1;
   localparam logic [1:0] EDGE_RIGHT  = 2'd2;
   localparam logic [1:0] EDGE_BOTTOM = 2'd3;

   // Bounding box corner selection per rotation quadrant: xmin, xmax, ymin, ymax.
   function automatic logic [7:0] box_sel(input logic [1:0] q);
      logic [7:0] r;
      case (q)
         2'd0: r = {2'd3, 2'd1, 2'd0, 2'd2};
         2'd1: r = {2'd2, 2'd0, 2'd3, 2'd1};
         2'd2: r = {2'd1, 2'd3, 2'd2, 2'd0};
         default: r = {2'd0, 2'd2, 2'd1, 2'd3};
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh007FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -40'sh0080000000) r = -32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// File: sv/rotated_tile_rect_clipper.sv
// An accepted request passes through the rotation multiplies and the sum, corner and cull
// states, then emits the results of a culled or unclipped tile; clipping adds a pass state
// per pass, a visit and a push state per visited vertex, and per edge crossing a product
// of two partial products and a restoring divide. Throughput: one request at a time;
// start is taken only while busy is low. Results appear one per cycle on rsp_strobe.
// The receiver cannot stall them. Reset (synchronous, active high) loads the register
// defaults and returns to idle.
module rotated_tile_rect_clipper (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_offset_x,
   input  logic signed [31:0] req_offset_y,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic               rsp_visible,
   output logic               rsp_last_vertex,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int MAX_VERTICES  = rtc_pkg::MAX_VERTICES;
   localparam int FRACTION_BITS = rtc_pkg::FRACTION_BITS;
   localparam int VW = $clog2(MAX_VERTICES + 1);
   localparam int IW = $clog2(MAX_VERTICES);
   localparam int QW = 72;
   localparam logic [VW-1:0] MAXV = VW'(MAX_VERTICES);

   // Configuration registers.
   logic signed [17:0] cos_ff, sin_ff;
   logic signed [31:0] sc_ff, ss_ff;
   logic [12:0] left_ff, width_ff, height_ff;
   logic signed [13:0] top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= 18'sd65536; sin_ff <= '0; sc_ff <= 32'sd32768; ss_ff <= '0;
         left_ff <= '0; top_ff <= '0; width_ff <= 13'd320; height_ff <= 13'd200;
      end else if (csr_write) begin
         case (csr_index)
            rtc_pkg::REG_COSINE:        cos_ff    <= csr_data[17:0];
            rtc_pkg::REG_SINE:          sin_ff    <= csr_data[17:0];
            rtc_pkg::REG_SCALED_COSINE: sc_ff     <= csr_data;
            rtc_pkg::REG_SCALED_SINE:   ss_ff     <= csr_data;
            rtc_pkg::REG_VIEW_LEFT:     left_ff   <= csr_data[12:0];
            rtc_pkg::REG_VIEW_TOP:      top_ff    <= csr_data[13:0];
            rtc_pkg::REG_VIEW_WIDTH:    width_ff  <= csr_data[12:0];
            default:                    height_ff <= csr_data[12:0];
         endcase
      end
   end

   // Viewport bounds, 40-bit signed fixed point.
   logic signed [39:0] bnd [4];
   always_comb begin
      bnd[0] = 40'(signed'({1'b0, left_ff})) <<< FRACTION_BITS;
      bnd[1] = 40'(top_ff) <<< FRACTION_BITS;
      bnd[2] = (40'(signed'({1'b0, left_ff})) + 40'(signed'({1'b0, width_ff})))
               <<< FRACTION_BITS;
      bnd[3] = (40'(top_ff) + 40'(signed'({1'b0, height_ff}))) <<< FRACTION_BITS;
   end

   rtc_pkg::state_type state_ff, state_in;

   // Vertex stores: current pass input (a) and output (b).
   logic signed [31:0] ax_ff [MAX_VERTICES];
   logic signed [31:0] ay_ff [MAX_VERTICES];
   logic signed [31:0] bx_ff [MAX_VERTICES];
   logic signed [31:0] by_ff [MAX_VERTICES];
   logic [VW-1:0] n_ff, m_ff;
   logic [IW-1:0] j_ff, s_ff;
   logic [1:0] edge_ff;
   logic [2:0] step_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic signed [49:0] prod_ff;
   logic signed [39:0] x0_ff, y0_ff;
   logic ein_ff, push_cross_ff, neg_ff;
   logic signed [39:0] cross_ff;
   logic signed [39:0] o1_ff;
   logic [QW-1:0] num_ff, quo_ff;
   logic [QW:0] rem_ff;
   logic [39:0] den_ff;
   logic [6:0] cnt_ff;

   // Shared 18x32 rotation multiplier operands.
   logic signed [31:0] mop;
   logic signed [17:0] mco;
   always_comb begin
      case (step_ff)
         3'd0: begin mop = ox_ff; mco = cos_ff; end
         3'd1: begin mop = oy_ff; mco = sin_ff; end
         3'd2: begin mop = ox_ff; mco = sin_ff; end
         default: begin mop = oy_ff; mco = cos_ff; end
      endcase
   end
   logic signed [49:0] mprod;
   assign mprod = 50'(mop) * 50'(mco);
   logic signed [39:0] mfl;
   assign mfl = 40'(prod_ff >>> FRACTION_BITS);

   logic axis_al;
   assign axis_al = (cos_ff == 0) || (sin_ff == 0);
   logic [1:0] quad;
   always_comb begin
      if (cos_ff > 0 && sin_ff >= 0) quad = 2'd0;
      else if (cos_ff <= 0 && sin_ff > 0) quad = 2'd1;
      else if (cos_ff < 0 && sin_ff <= 0) quad = 2'd2;
      else quad = 2'd3;
   end
   logic [7:0] sel;
   assign sel = rtc_pkg::box_sel(quad);
   logic signed [39:0] xmin, xmax, ymin, ymax;
   assign xmin = 40'(ax_ff[sel[7:6]]);
   assign xmax = 40'(ax_ff[sel[5:4]]);
   assign ymin = 40'(ay_ff[sel[3:2]]);
   assign ymax = 40'(ay_ff[sel[1:0]]);
   logic culled, clipped;
   assign culled  = xmax < bnd[0] || xmin > bnd[2] || ymax < bnd[1] || ymin > bnd[3];
   assign clipped = ymax > bnd[3] || ymin < bnd[1] || xmax > bnd[2] || xmin < bnd[0];

   function automatic logic is_in(input logic [1:0] e, input logic signed [31:0] x,
                                  input logic signed [31:0] y,
                                  input logic signed [39:0] b);
      logic r;
      case (e)
         rtc_pkg::EDGE_LEFT:  r = 40'(x) > b;
         rtc_pkg::EDGE_TOP:   r = 40'(y) > b;
         rtc_pkg::EDGE_RIGHT: r = 40'(x) < b;
         default:             r = 40'(y) < b;
      endcase
      return r;
   endfunction

   logic signed [39:0] bcur;
   assign bcur = bnd[edge_ff];
   logic ein, sin_in;
   assign ein    = is_in(edge_ff, ax_ff[j_ff], ay_ff[j_ff], bcur);
   assign sin_in = is_in(edge_ff, ax_ff[s_ff], ay_ff[s_ff], bcur);

   // Crossing operands: n is the boundary-normal axis, o the other axis.
   logic signed [39:0] n1, o1, n2, o2, d_o, d_t, d_n;
   always_comb begin
      if (edge_ff[0]) begin
         n1 = 40'(ay_ff[j_ff]); o1 = 40'(ax_ff[j_ff]);
         n2 = 40'(ay_ff[s_ff]); o2 = 40'(ax_ff[s_ff]);
      end else begin
         n1 = 40'(ax_ff[j_ff]); o1 = 40'(ay_ff[j_ff]);
         n2 = 40'(ax_ff[s_ff]); o2 = 40'(ay_ff[s_ff]);
      end
      d_o = o2 - o1;
      d_t = n1 - bcur;
      d_n = n1 - n2;
   end
   logic [39:0] mag_o, mag_t, mag_n;
   assign mag_o = d_o[39] ? 40'(-d_o) : 40'(d_o);
   assign mag_t = d_t[39] ? 40'(-d_t) : 40'(d_t);
   assign mag_n = d_n[39] ? 40'(-d_n) : 40'(d_n);

   // Product of magnitudes taken as two 40x20 partial products, low half first.
   logic [QW-1:0] pp;
   assign pp = cnt_ff[0] ? (QW'(mag_o) * QW'(mag_t[39:20])) << 20
                         : QW'(mag_o) * QW'(mag_t[19:0]);

   logic [QW:0] rsh;
   assign rsh = {rem_ff[QW-1:0], num_ff[QW-1]};
   logic rge;
   assign rge = rsh >= {{(QW-40+1){1'b0}}, den_ff};

   logic signed [39:0] q_signed, cross_val;
   assign q_signed = 40'(quo_ff);
   assign cross_val = neg_ff ? o1_ff - q_signed : o1_ff + q_signed;

   logic [IW-1:0] last_idx;
   assign last_idx = IW'(n_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtc_pkg::ST_IDLE:   if (start) state_in = rtc_pkg::ST_MUL;
         rtc_pkg::ST_MUL:    if (step_ff == 3'd4) state_in = rtc_pkg::ST_SUM;
         rtc_pkg::ST_SUM:    state_in = rtc_pkg::ST_CORNER;
         rtc_pkg::ST_CORNER: state_in = rtc_pkg::ST_CULL;
         rtc_pkg::ST_CULL: begin
            if (culled) state_in = rtc_pkg::ST_EMIT;
            else if (clipped) state_in = rtc_pkg::ST_PASS;
            else state_in = rtc_pkg::ST_EMIT;
         end
         rtc_pkg::ST_PASS: state_in = (n_ff == 0) ? rtc_pkg::ST_EMIT : rtc_pkg::ST_VISIT;
         rtc_pkg::ST_VISIT: begin
            if (ein != sin_in && m_ff < MAXV) begin
               if (edge_ff[0] && axis_al) state_in = rtc_pkg::ST_PUSH;
               else if (d_n == 0) state_in = rtc_pkg::ST_PUSH;
               else state_in = rtc_pkg::ST_MULX;
            end else state_in = rtc_pkg::ST_PUSH;
         end
         rtc_pkg::ST_MULX:  if (cnt_ff[0]) state_in = rtc_pkg::ST_DIV;
         rtc_pkg::ST_DIV:   if (cnt_ff == 7'(QW)) state_in = rtc_pkg::ST_PUSH;
         rtc_pkg::ST_PUSH: begin
            if (j_ff == 0) begin
               if (edge_ff == rtc_pkg::EDGE_BOTTOM) state_in = rtc_pkg::ST_EMIT;
               else state_in = rtc_pkg::ST_PASS;
            end else state_in = rtc_pkg::ST_VISIT;
         end
         rtc_pkg::ST_EMIT: if (n_ff == 0 || {1'b0, step_ff} == 4'(n_ff - 1'b1))
                              state_in = rtc_pkg::ST_IDLE;
         default: state_in = rtc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rtc_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   logic signed [31:0] push_x, push_y;
   always_comb begin
      push_x = ax_ff[j_ff];
      push_y = ay_ff[j_ff];
   end

   // Up to two stores per visit: the crossing point first, then the kept vertex.
   logic signed [31:0] cross_x, cross_y;
   logic wr0_en, wr1_en;
   logic [IW-1:0] wr0_idx, wr1_idx;
   logic signed [31:0] wr0_x, wr0_y;
   logic [VW-1:0] m_next;
   always_comb begin
      cross_x = edge_ff[0] ? rtc_pkg::sat32(cross_ff) : rtc_pkg::sat32(bcur);
      cross_y = edge_ff[0] ? rtc_pkg::sat32(bcur) : rtc_pkg::sat32(cross_ff);
      wr0_en  = 1'b0;
      wr1_en  = 1'b0;
      wr0_idx = IW'(m_ff);
      wr1_idx = IW'(m_ff + 1'b1);
      wr0_x   = push_x;
      wr0_y   = push_y;
      m_next  = m_ff;
      if (push_cross_ff) begin
         wr0_en = 1'b1;
         wr0_x  = cross_x;
         wr0_y  = cross_y;
         if (ein_ff && m_ff + 1'b1 < MAXV) begin
            wr1_en = 1'b1;
            m_next = m_ff + VW'(2);
         end else m_next = m_ff + 1'b1;
      end else if (ein_ff && m_ff < MAXV) begin
         wr0_en = 1'b1;
         m_next = m_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rtc_pkg::ST_IDLE: begin
            ox_ff <= req_offset_x; oy_ff <= req_offset_y;
            step_ff <= '0;
         end
         rtc_pkg::ST_MUL: begin
            prod_ff <= mprod;
            step_ff <= step_ff + 3'd1;
            case (step_ff)
               3'd1: x0_ff <= mfl;
               3'd2: x0_ff <= x0_ff - mfl;
               3'd3: y0_ff <= mfl;
               3'd4: y0_ff <= y0_ff + mfl;
               default: ;
            endcase
         end
         rtc_pkg::ST_SUM: begin
            x0_ff <= x0_ff + (40'(signed'({1'b0, width_ff})) <<< (FRACTION_BITS - 1))
                     + bnd[0];
            y0_ff <= y0_ff + (40'(signed'({1'b0, height_ff})) <<< (FRACTION_BITS - 1))
                     + bnd[1];
         end
         rtc_pkg::ST_CORNER: begin
            ax_ff[0] <= rtc_pkg::sat32(x0_ff);
            ay_ff[0] <= rtc_pkg::sat32(y0_ff);
            ax_ff[1] <= rtc_pkg::sat32(x0_ff + 40'(sc_ff));
            ay_ff[1] <= rtc_pkg::sat32(y0_ff + 40'(ss_ff));
            ax_ff[2] <= rtc_pkg::sat32(x0_ff + 40'(sc_ff) - 40'(ss_ff));
            ay_ff[2] <= rtc_pkg::sat32(y0_ff + 40'(ss_ff) + 40'(sc_ff));
            ax_ff[3] <= rtc_pkg::sat32(x0_ff - 40'(ss_ff));
            ay_ff[3] <= rtc_pkg::sat32(y0_ff + 40'(sc_ff));
            n_ff <= VW'(4);
            edge_ff <= rtc_pkg::EDGE_LEFT;
         end
         rtc_pkg::ST_CULL: begin
            if (culled) n_ff <= '0;
            step_ff <= '0;
            m_ff <= '0;
         end
         rtc_pkg::ST_PASS: begin
            m_ff <= '0;
            s_ff <= '0;
            j_ff <= last_idx;
            step_ff <= '0;
         end
         rtc_pkg::ST_VISIT: begin
            ein_ff <= ein;
            o1_ff <= o1;
            neg_ff <= (d_o[39] != d_t[39]) != d_n[39];
            push_cross_ff <= (ein != sin_in) && m_ff < MAXV;
            cross_ff <= (edge_ff[0] && axis_al) ? o1 : o1;
            num_ff <= '0;
            rem_ff <= '0;
            den_ff <= mag_n;
            cnt_ff <= '0;
         end
         rtc_pkg::ST_MULX: begin
            num_ff <= num_ff + pp;
            cnt_ff <= cnt_ff[0] ? '0 : cnt_ff + 7'd1;
         end
         rtc_pkg::ST_DIV: begin
            if (cnt_ff == 7'(QW)) begin
               cross_ff <= cross_val;
            end else begin
               rem_ff  <= rge ? rsh - {{(QW-40+1){1'b0}}, den_ff} : rsh;
               num_ff  <= {num_ff[QW-2:0], 1'b0};
               quo_ff  <= {quo_ff[QW-2:0], rge};
               cnt_ff  <= cnt_ff + 7'd1;
            end
         end
         rtc_pkg::ST_PUSH: begin
            if (wr0_en) begin
               bx_ff[wr0_idx] <= wr0_x;
               by_ff[wr0_idx] <= wr0_y;
            end
            if (wr1_en) begin
               bx_ff[wr1_idx] <= push_x;
               by_ff[wr1_idx] <= push_y;
            end
            m_ff <= m_next;
            push_cross_ff <= 1'b0;
            s_ff <= j_ff;
            if (j_ff != 0) j_ff <= j_ff - 1'b1;
            else begin
               // End of pass: output store, with this visit's stores, becomes next input.
               edge_ff <= edge_ff + 2'd1;
               n_ff <= m_next;
               for (int i = 0; i < MAX_VERTICES; i++) begin
                  if (wr0_en && IW'(i) == wr0_idx) begin
                     ax_ff[i] <= wr0_x;
                     ay_ff[i] <= wr0_y;
                  end else if (wr1_en && IW'(i) == wr1_idx) begin
                     ax_ff[i] <= push_x;
                     ay_ff[i] <= push_y;
                  end else begin
                     ax_ff[i] <= bx_ff[i];
                     ay_ff[i] <= by_ff[i];
                  end
               end
            end
            step_ff <= '0;
         end
         rtc_pkg::ST_EMIT: step_ff <= step_ff + 3'd1;
         default: ;
      endcase
   end

   logic [IW-1:0] eidx;
   assign eidx = IW'(step_ff);

   always_comb begin
      busy = (state_ff != rtc_pkg::ST_IDLE);
      rsp_strobe = (state_ff == rtc_pkg::ST_EMIT);
      rsp_visible = (n_ff != 0);
      rsp_vertex_x = (n_ff != 0) ? ax_ff[eidx] : '0;
      rsp_vertex_y = (n_ff != 0) ? ay_ff[eidx] : '0;
      rsp_last_vertex = (n_ff == 0) || ({1'b0, step_ff} == 4'(n_ff - 1'b1));
   end

`ifndef ASSERT_OFF
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe while idle");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_vertex) |=> !busy) else $error("no idle after last");
   a_cull_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_visible) |-> rsp_last_vertex) else $error("culled not last");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> n_ff <= MAXV) else $error("vertex count overflow");
`endif

endmodule
